// File: rtl/uqst_pkg.sv
// Package: word types, character codes and counter helpers for the URL query tokenizer.
`timescale 1ns / 1ps

package uqst_pkg;

  // Field limit of the query parser; the counters are 5 bits wide.
  localparam int MAX_FIELDS = 16;
  localparam int COUNT_CAP_I = (MAX_FIELDS > 31) ? 31 : MAX_FIELDS;
  localparam int SLOT_MAX_I = ((COUNT_CAP_I - 1) > 15) ? 15 : (COUNT_CAP_I - 1);

  localparam logic [4:0] COUNT_CAP = 5'(COUNT_CAP_I);
  localparam logic [4:0] SLOT_MAX = 5'(SLOT_MAX_I);

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQUALS = 8'h3D;

  typedef struct packed {
    logic [7:0] url_byte;
    logic last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic is_path;
    logic is_name;
    logic [3:0] name_slot;
    logic name_done;
    logic is_value;
    logic [3:0] value_slot;
    logic [4:0] param_count;
    logic [4:0] value_count;
    logic url_error;
    logic done_res;
  } out_word_t;

  // Saturating increment at the field cap.
  function automatic logic [4:0] sat_inc(input logic [4:0] v);
    return (v < COUNT_CAP) ? v + 5'd1 : v;
  endfunction

  // Clamp a running count to a 4-bit slot index.
  function automatic logic [3:0] slot_of(input logic [4:0] count);
    logic [4:0] s;
    s = (count >= SLOT_MAX) ? SLOT_MAX : count;
    return s[3:0];
  endfunction

endpackage

// File: rtl/url_query_string_tokenizer.sv
// Top level: labels each URL byte as path, parameter name or value, with running counts.
`timescale 1ns / 1ps

// URL query string tokenizer.
// Input channel: one URL byte per word (in_data.url_byte), with in_data.last_byte
// marking the final byte of a URL. A word is taken when in_valid is high and
// in_stall is low.
// Output channel: one result word per input word, in order, carrying the byte,
// its path/name/value labels, slot indexes, running counts and the sticky error.
// Registering: each result word is held in the output register, or in the skid
// stage while the receiver stalls. Throughput: one word per cycle while in_stall
// is low; the tracker state updates on each taken byte, so consecutive bytes never wait on each other.
// Stall: the output register is backed by one skid stage, so a word is still
// taken in the cycle the receiver first stalls. in_stall rises only while the
// skid stage is full and drops as soon as the receiver drains it.
// Reset (rst_n low, synchronous): both stages empty, all trackers cleared.
// After a word with last_byte set, every tracker returns to its reset value,
// so the next byte starts a new URL.
module url_query_string_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  uqst_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output uqst_pkg::out_word_t out_data
);

  // Tracker state.
  logic       seen_question_r, seen_question_nxt;
  logic       name_active_r, name_active_nxt;
  logic       name_nonempty_r, name_nonempty_nxt;
  logic       value_active_r, value_active_nxt;
  logic       value_nonempty_r, value_nonempty_nxt;
  logic       value_stopped_r, value_stopped_nxt;
  logic       error_seen_r, error_seen_nxt;
  logic [7:0] previous_byte_r, previous_byte_nxt;
  logic [4:0] names_counted_r, names_counted_nxt;
  logic [4:0] values_seen_r, values_seen_nxt;
  logic [4:0] values_counted_r, values_counted_nxt;

  // Output register and skid stage.
  logic                out_valid_r;
  uqst_pkg::out_word_t out_r;
  logic                skid_valid_r;
  uqst_pkg::out_word_t skid_r;

  uqst_pkg::out_word_t res;
  logic                accept;
  logic [7:0]          b;
  logic                last;
  logic                close_name;
  logic                close_value;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign b         = in_data.url_byte;
  assign last      = in_data.last_byte;

  // Per-byte tracker update and result.
  always_comb begin
    seen_question_nxt  = seen_question_r;
    name_active_nxt    = name_active_r;
    name_nonempty_nxt  = name_nonempty_r;
    value_active_nxt   = value_active_r;
    value_nonempty_nxt = value_nonempty_r;
    value_stopped_nxt  = value_stopped_r;
    error_seen_nxt     = error_seen_r;
    names_counted_nxt  = names_counted_r;
    values_seen_nxt    = values_seen_r;
    values_counted_nxt = values_counted_r;
    previous_byte_nxt  = b;
    close_name         = 1'b0;
    close_value        = 1'b0;

    res            = '0;
    res.echo_byte  = b;
    res.is_path    = !seen_question_r && (b != uqst_pkg::CH_QUESTION);
    res.done_res   = last;

    if (b == uqst_pkg::CH_QUESTION) begin
      seen_question_nxt = 1'b1;
    end

    // Name tracker: opens on '?' or '&', closes on '=' or the final byte.
    if (name_active_r) begin
      if (b == uqst_pkg::CH_EQUALS) begin
        close_name = 1'b1;
      end else begin
        res.is_name       = 1'b1;
        res.name_slot     = uqst_pkg::slot_of(names_counted_r);
        name_nonempty_nxt = 1'b1;
        close_name        = last;
      end
      if (close_name) begin
        if (name_nonempty_nxt) begin
          names_counted_nxt = uqst_pkg::sat_inc(names_counted_r);
          res.name_done     = 1'b1;
        end
        name_active_nxt   = 1'b0;
        name_nonempty_nxt = 1'b0;
      end
    end else if (b == uqst_pkg::CH_QUESTION || b == uqst_pkg::CH_AMP) begin
      name_active_nxt   = 1'b1;
      name_nonempty_nxt = 1'b0;
    end

    // Value tracker: opens on '=', closes on '&' or the final byte; halts on error.
    if (!value_stopped_r) begin
      if (value_active_r) begin
        if (b == uqst_pkg::CH_AMP) begin
          close_value = 1'b1;
        end else begin
          res.is_value       = 1'b1;
          res.value_slot     = uqst_pkg::slot_of(values_seen_r);
          value_nonempty_nxt = 1'b1;
          close_value        = last;
        end
      end else if (b == uqst_pkg::CH_EQUALS) begin
        if (previous_byte_r == uqst_pkg::CH_QUESTION ||
            previous_byte_r == uqst_pkg::CH_AMP) begin
          error_seen_nxt    = 1'b1;
          value_stopped_nxt = 1'b1;
        end else begin
          value_active_nxt   = 1'b1;
          value_nonempty_nxt = 1'b0;
          close_value        = last;
        end
      end
      if (close_value) begin
        values_seen_nxt = uqst_pkg::sat_inc(values_seen_r);
        if (value_nonempty_nxt) begin
          values_counted_nxt = uqst_pkg::sat_inc(values_counted_r);
        end
        value_active_nxt   = 1'b0;
        value_nonempty_nxt = 1'b0;
      end
    end

    res.param_count = names_counted_nxt;
    res.value_count = values_counted_nxt;
    res.url_error   = error_seen_nxt;
  end

  // Tracker registers: advance on each taken word, clear at the end of a URL.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      seen_question_r  <= 1'b0;
      name_active_r    <= 1'b0;
      name_nonempty_r  <= 1'b0;
      value_active_r   <= 1'b0;
      value_nonempty_r <= 1'b0;
      value_stopped_r  <= 1'b0;
      error_seen_r     <= 1'b0;
      previous_byte_r  <= 8'h00;
      names_counted_r  <= 5'd0;
      values_seen_r    <= 5'd0;
      values_counted_r <= 5'd0;
    end else if (accept) begin
      seen_question_r  <= seen_question_nxt;
      name_active_r    <= name_active_nxt;
      name_nonempty_r  <= name_nonempty_nxt;
      value_active_r   <= value_active_nxt;
      value_nonempty_r <= value_nonempty_nxt;
      value_stopped_r  <= value_stopped_nxt;
      error_seen_r     <= error_seen_nxt;
      previous_byte_r  <= previous_byte_nxt;
      names_counted_r  <= names_counted_nxt;
      values_seen_r    <= values_seen_nxt;
      values_counted_r <= values_counted_nxt;
    end
  end

  // Output register with skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      // Hold the output; park a new word in the skid stage.
      if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      // Drain the skid stage first; no word is taken in this state.
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (accept) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (accept) begin
      out_r <= res;
    end
  end

endmodule

// File: bench/tb_url_query_string_tokenizer.sv
// Testbench for the URL query string tokenizer: byte-label predictor, scoreboard and drivers.
`timescale 1ns / 1ps

// Predicts the label word for every URL byte the block takes, and checks the
// words it returns, in order, field by field.
class byte_label_board;
  uqst_pkg::out_word_t labels_due[$];
  int error_count;
  int words_checked;

  // Tracker state for the URL in flight.
  bit in_query, name_open, name_has_chars;
  bit value_open, value_has_chars, value_halted, bad_equals;
  logic [7:0] prior_byte;
  logic [4:0] names_done_cnt, values_opened, values_filled;

  function new();
    error_count = 0;
    words_checked = 0;
    clear_url();
  endfunction

  function void clear_url();
    in_query = 0;
    name_open = 0;
    name_has_chars = 0;
    value_open = 0;
    value_has_chars = 0;
    value_halted = 0;
    bad_equals = 0;
    prior_byte = '0;
    names_done_cnt = '0;
    values_opened = '0;
    values_filled = '0;
  endfunction

  function int unsigned field_cap();
    return (uqst_pkg::MAX_FIELDS > 31) ? 31 : uqst_pkg::MAX_FIELDS;
  endfunction

  function logic [4:0] bump(input logic [4:0] v);
    return (v < field_cap()) ? v + 5'd1 : v;
  endfunction

  function logic [3:0] slot_index(input logic [4:0] count);
    int unsigned s;
    s = count;
    if (s >= field_cap()) s = field_cap() - 1;
    if (s > 15) s = 15;
    return s[3:0];
  endfunction

  function int pending();
    return labels_due.size();
  endfunction

  // Work out the label word for one accepted URL byte.
  function void note_byte(input uqst_pkg::in_word_t w);
    uqst_pkg::out_word_t r;
    logic [7:0] c;
    bit fin;
    bit shut_value;
    c = w.url_byte;
    fin = w.last_byte;
    shut_value = 0;
    r = '0;
    r.echo_byte = c;
    r.done_res = fin;
    r.is_path = !in_query && (c != uqst_pkg::CH_QUESTION);
    if (c == uqst_pkg::CH_QUESTION) in_query = 1;

    if (name_open) begin
      if (c != uqst_pkg::CH_EQUALS) begin
        r.is_name = 1;
        r.name_slot = slot_index(names_done_cnt);
        name_has_chars = 1;
      end
      if (c == uqst_pkg::CH_EQUALS || fin) begin
        if (name_has_chars) begin
          names_done_cnt = bump(names_done_cnt);
          r.name_done = 1;
        end
        name_open = 0;
        name_has_chars = 0;
      end
    end else if (c == uqst_pkg::CH_QUESTION || c == uqst_pkg::CH_AMP) begin
      name_open = 1;
      name_has_chars = 0;
    end

    if (!value_halted) begin
      if (value_open) begin
        if (c == uqst_pkg::CH_AMP) begin
          shut_value = 1;
        end else begin
          r.is_value = 1;
          r.value_slot = slot_index(values_opened);
          value_has_chars = 1;
          shut_value = fin;
        end
      end else if (c == uqst_pkg::CH_EQUALS) begin
        if (prior_byte == uqst_pkg::CH_QUESTION || prior_byte == uqst_pkg::CH_AMP) begin
          bad_equals = 1;
          value_halted = 1;
        end else begin
          value_open = 1;
          value_has_chars = 0;
          shut_value = fin;
        end
      end
      if (shut_value) begin
        values_opened = bump(values_opened);
        if (value_has_chars) values_filled = bump(values_filled);
        value_open = 0;
        value_has_chars = 0;
      end
    end

    prior_byte = c;
    r.param_count = names_done_cnt;
    r.value_count = values_filled;
    r.url_error = bad_equals;
    labels_due.push_back(r);
    if (fin) clear_url();
  endfunction

  task report(input string msg);
    error_count++;
    if (error_count <= 100) $display("MISMATCH word %0d: %s", words_checked, msg);
  endtask

  task check_field(input string field, input int unsigned got, input int unsigned want,
                   input bit has_x);
    if (has_x || got != want)
      report($sformatf("%s got %0h want %0h", field, got, want));
  endtask

  // Compare one returned word with the oldest label still due.
  task check_label(input uqst_pkg::out_word_t got);
    uqst_pkg::out_word_t want;
    if (labels_due.size() == 0) begin
      report($sformatf("word with byte %02h arrived with nothing due", got.echo_byte));
      return;
    end
    want = labels_due.pop_front();
    check_field("echo_byte", got.echo_byte, want.echo_byte, $isunknown(got.echo_byte));
    check_field("is_path", got.is_path, want.is_path, $isunknown(got.is_path));
    check_field("is_name", got.is_name, want.is_name, $isunknown(got.is_name));
    check_field("name_slot", got.name_slot, want.name_slot, $isunknown(got.name_slot));
    check_field("name_done", got.name_done, want.name_done, $isunknown(got.name_done));
    check_field("is_value", got.is_value, want.is_value, $isunknown(got.is_value));
    check_field("value_slot", got.value_slot, want.value_slot, $isunknown(got.value_slot));
    check_field("param_count", got.param_count, want.param_count,
                $isunknown(got.param_count));
    check_field("value_count", got.value_count, want.value_count,
                $isunknown(got.value_count));
    check_field("url_error", got.url_error, want.url_error, $isunknown(got.url_error));
    check_field("done_res", got.done_res, want.done_res, $isunknown(got.done_res));
    words_checked++;
  endtask
endclass

module tb_url_query_string_tokenizer;

  typedef logic [7:0] url_chars_t[$];

  localparam int TOTAL_ITEMS = 1550;
  // Past this many bytes both sides run flat out.
  localparam int CALM_FROM = 1300;
  // Start the long receiver hold-off around here.
  localparam int PRESSURE_AT = 300;
  localparam int HOLD_CYCLES = 60;
  // Wait this long after the drain, so any extra word from the block still shows.
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_GUARD = 2000;
  localparam time RUN_LIMIT = 5ms;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  uqst_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  uqst_pkg::out_word_t out_data;

  byte_label_board board;

  // Idle rates in percent, chosen per URL by the main sequence.
  int gap_pct;
  int stall_pct;
  // Raised by the main sequence; the receiver clears it once the hold-off is over.
  bit hold_off_req;
  int bytes_sent;

  url_query_string_tokenizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge. Note the incoming word before
  // checking the outgoing one, so ordering never depends on process scheduling.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_data);
      if (out_valid && !out_stall) board.check_label(out_data);
    end
  end

  // Receiver: stall in random bursts, or hold off for a long stretch on request
  // so the block fills up and has to stall its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_off_req = 0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("tb_url_query_string_tokenizer: done, errors");
    $finish;
  end

  // Offer one word; hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic lst);
    int n;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 15);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{url_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall);
  endtask

  // Send a whole URL; the final byte carries last_byte.
  task automatic send_url(input url_chars_t chars);
    foreach (chars[i]) send_word(chars[i], i == chars.size() - 1);
    bytes_sent += chars.size();
  endtask

  // Any byte but a separator; still sweeps every bit.
  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == uqst_pkg::CH_QUESTION || b == uqst_pkg::CH_AMP || b == uqst_pkg::CH_EQUALS)
      b = b ^ 8'h40;
    return b;
  endfunction

  // Bytes weighted toward the separators.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return uqst_pkg::CH_QUESTION;
      1: return uqst_pkg::CH_AMP;
      2: return uqst_pkg::CH_EQUALS;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed URLs with random content. A big URL carries 15 to 20
  // clean name=value pairs, which can drive both counts into saturation; a few URLs
  // are pure noise or get a stray noise byte dropped in.
  function automatic url_chars_t random_url(input bit force_big);
    url_chars_t q;
    int pick;
    int n_params;
    bit big;
    pick = $urandom_range(0, 9);
    big = force_big || ($urandom_range(0, 7) == 0);
    if (pick == 0 && !force_big) begin
      repeat ($urandom_range(1, 12)) q.push_back(noise_char());
    end else begin
      repeat ($urandom_range(0, 4)) q.push_back(plain_char());
      if (big || $urandom_range(0, 7) != 0) begin
        q.push_back(uqst_pkg::CH_QUESTION);
        n_params = big ? $urandom_range(15, 20) : $urandom_range(0, 4);
        for (int p = 0; p < n_params; p++) begin
          if (p > 0) q.push_back(uqst_pkg::CH_AMP);
          repeat (big ? $urandom_range(1, 3) : $urandom_range(0, 3)) q.push_back(plain_char());
          if (big || $urandom_range(0, 4) != 0) begin
            q.push_back(uqst_pkg::CH_EQUALS);
            repeat (big ? $urandom_range(1, 3) : $urandom_range(0, 3))
              q.push_back(plain_char());
          end
        end
      end
      if (pick == 1 && !force_big && q.size() > 0)
        q.insert($urandom_range(0, q.size() - 1), noise_char());
    end
    if (q.size() == 0) q.push_back(plain_char());
    return q;
  endfunction

  initial begin
    int guard;
    bit pressure_done;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    gap_pct = 20;
    stall_pct = 20;
    hold_off_req = 0;
    bytes_sent = 0;
    pressure_done = 0;
    guard = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed URLs.
    // Zero byte in the path, a value holding '=', '&' closing it, a name
    // left open on the final byte.
    send_url('{8'h00, "/", uqst_pkg::CH_QUESTION, "k", uqst_pkg::CH_EQUALS, "v",
               uqst_pkg::CH_EQUALS, uqst_pkg::CH_AMP, "x"});
    // '=' as the very first byte (no error) opens a value that also takes '?=',
    // so no error is set; '&b=' completes a name.
    send_url('{uqst_pkg::CH_EQUALS, 8'hFF, uqst_pkg::CH_QUESTION, uqst_pkg::CH_EQUALS,
               "a", uqst_pkg::CH_AMP, "b", uqst_pkg::CH_EQUALS});
    // '?' inside a name, an empty value closed by '&', a value closed by the
    // final byte.
    send_url('{uqst_pkg::CH_QUESTION, "a", uqst_pkg::CH_QUESTION, "b", uqst_pkg::CH_EQUALS,
               uqst_pkg::CH_AMP, "c", uqst_pkg::CH_EQUALS, "d"});
    // One-byte URLs: a lone '?', and a lone '=' that opens an empty value.
    send_url('{uqst_pkg::CH_QUESTION});
    send_url('{uqst_pkg::CH_EQUALS});

    // Random URLs; idle rates change per URL and include zero.
    while (bytes_sent < TOTAL_ITEMS) begin
      if (bytes_sent >= CALM_FROM) begin
        gap_pct = 0;
        stall_pct = 0;
        send_url(random_url(0));
      end else if (!pressure_done && bytes_sent >= PRESSURE_AT) begin
        // Keep offering with no gaps while the receiver holds off.
        pressure_done = 1;
        gap_pct = 0;
        stall_pct = 0;
        hold_off_req = 1;
        send_url(random_url(1));
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 30;
        endcase
        send_url(random_url(0));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain, then give the block a few more cycles to show any extra word.
    while (board.pending() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d labels never returned", board.pending()));

    if (board.error_count == 0) begin
      $display("tb_url_query_string_tokenizer: done, clean");
    end else begin
      $display("tb_url_query_string_tokenizer: done, errors");
    end
    $finish;
  end

endmodule

// File: url_query_string_tokenizer.f
rtl/uqst_pkg.sv
rtl/url_query_string_tokenizer.sv
bench/tb_url_query_string_tokenizer.sv
